// ===== design/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg - star wildcard matcher shared types
// Opcodes, the star byte, cell control and neighbor link structs.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam logic [7:0] STAR_BYTE = 8'd42;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_WORD   = 2'd2
  } swm_op_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic       clear;    // clear pattern
    logic       append;   // append pattern byte
    logic       step;     // word byte
    logic       abandon;  // drop the active positions
    logic       started;  // word in progress
    logic [7:0] char_b;   // item byte
  } swm_ctrl_t;

  // handed from cell i to cell i+1
  typedef struct packed {
    logic lit;    // literal match moves into next position
    logic close;  // star closure carry
    logic init;   // start-vector bit of this position
  } swm_link_t;

endpackage

// ===== design/star_wildcard_matcher.sv =====
// ----------------------------------------------------------------------------
// star_wildcard_matcher - star-only wildcard match over a byte stream
// Pattern bytes load into a row of cells; word bytes advance an active
// position vector through the row, one byte per cycle while in_tready is high.
//
//   channel | dir | tdata         | tuser       | tlast
//   in_     | in  | [7:0] char_in | [1:0] opcode| word_last
//   out_    | out | [0] matched   | -           | -
//
// One item per cycle on the input while in_tready is high. The match bit is
// registered and shows in the cycle after the last word byte. The ripple of
// the star closure and literal match through the MAX_PATTERN cells sets the
// clock period. Reset is synchronous; pattern bytes are not reset, no clearing
// pass. in_tready drops only while a result waits and out_tready is low.
// ----------------------------------------------------------------------------
module star_wildcard_matcher #(
  parameter int MAX_PATTERN = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_in
  input  logic [1:0] in_tuser,   // [1:0] opcode
  input  logic       in_tlast,   // word_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] matched, [7:1] zero
);
  import swm_pkg::*;

  localparam int LW = $clog2(MAX_PATTERN + 1);

  logic [LW-1:0]      len_r, len_nxt;
  logic               ovf_r, ovf_nxt;
  logic               started_r, started_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_matched_r;
  logic               in_acc, hit, result_now;
  swm_ctrl_t          ctrl;
  swm_link_t          link [MAX_PATTERN+1];
  logic [MAX_PATTERN:0] closed_vec;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    ctrl        = '0;
    ctrl.char_b = in_tdata;
    ctrl.started = started_r;
    if (in_acc) begin
      unique case (swm_op_t'(in_tuser))
        OP_CLEAR:  ctrl.clear  = 1'b1;
        OP_APPEND: ctrl.append = 1'b1;
        OP_WORD:   ctrl.step   = 1'b1;
        default:   ;
      endcase
    end
    ctrl.abandon = ctrl.clear || ctrl.append || (ctrl.step && in_tlast);
  end

  assign link[0] = '0;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    swm_cell #(
      .IDX (i),
      .LW  (LW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .len      (len_r),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .closed_o (closed_vec[i])
    );
  end

  assign closed_vec[MAX_PATTERN] = link[MAX_PATTERN].lit | link[MAX_PATTERN].close;

  assign hit        = !ovf_r && closed_vec[len_r];
  assign result_now = ctrl.step && in_tlast;

  always_comb begin
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.clear) begin
      len_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (ctrl.append) begin
      if (len_r < LW'(MAX_PATTERN)) begin
        len_nxt = len_r + LW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (ctrl.abandon) begin
      started_nxt = 1'b0;
    end else if (ctrl.step) begin
      started_nxt = 1'b1;
    end
    if (result_now) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (result_now) begin
      out_matched_r <= hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_matched_r};

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(MAX_PATTERN))
    else $error("pattern length beyond store");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (len_r == LW'(MAX_PATTERN)))
    else $error("overflow without full store");

  a_ovf_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    (result_now && ovf_r) |=> (out_tvalid && !out_tdata[0]))
    else $error("match reported after overflow");

  a_empty_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    (result_now && (len_r == '0)) |=> (out_tvalid && !out_tdata[0]))
    else $error("empty pattern matched");

endmodule

// ===== design/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell - one pattern position
// Holds one pattern byte, its active bit and its start-vector bit.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int IDX = 0,
  parameter int LW  = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  swm_pkg::swm_ctrl_t ctrl,
  input  logic [LW-1:0]     len,
  input  swm_pkg::swm_link_t link_in,
  output swm_pkg::swm_link_t link_out,
  output logic              closed_o
);
  import swm_pkg::*;

  logic [7:0] p_r;
  logic       a_r, a_nxt;
  logic       init_r, init_nxt;
  logic       valid, is_star, cur_a, self_act, closed;

  assign valid    = (len > LW'(IDX));
  assign is_star  = (p_r == STAR_BYTE);
  assign cur_a    = ctrl.started ? a_r : init_r;
  assign self_act = cur_a & is_star & valid;
  assign closed   = self_act | link_in.lit | link_in.close;

  assign link_out.lit   = cur_a & valid & ~is_star & (p_r == ctrl.char_b);
  assign link_out.close = closed & is_star & valid;
  assign link_out.init  = init_r;
  assign closed_o       = closed;

  always_comb begin
    a_nxt = a_r;
    if (ctrl.abandon) begin
      a_nxt = 1'b0;
    end else if (ctrl.step) begin
      a_nxt = closed;
    end
  end

  always_comb begin
    init_nxt = init_r;
    if (ctrl.clear) begin
      init_nxt = (IDX == 0);
    end else if ((IDX != 0) && ctrl.append && (len == LW'(IDX - 1))) begin
      init_nxt = link_in.init & (ctrl.char_b == STAR_BYTE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r    <= 1'b0;
      init_r <= (IDX == 0);
    end else begin
      a_r    <= a_nxt;
      init_r <= init_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.append && (len == LW'(IDX))) begin
      p_r <= ctrl.char_b;
    end
  end

endmodule
